// ===== rtl/core/m4rm_pkg.sv =====
// Shared types and constants for the 4x4 fixed-point row multiplier.
package m4rm_pkg;

    localparam int DIM           = 4;
    localparam int ELEM_W        = 32;
    localparam int ROW_W         = 2;
    localparam int FRAC_BITS_DEF = 16;
    localparam int PROD_W        = 2 * ELEM_W;
    localparam int PAIR_W        = PROD_W + 1;
    localparam int SUM_W         = PROD_W + 2;

    // Operation codes on the func input
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_MUL  = 1'b1;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic        [ROW_W-1:0]  row_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [PAIR_W-1:0] pair_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

endpackage

// ===== rtl/core/matrix4_row_multiply.sv =====
// Row-streamed 4x4 signed fixed-point matrix multiplier with a stored right-hand matrix.
//
// Command-style block. A transfer happens on a rising edge with start high and
// busy low; busy is held low, so one row can be issued in every cycle. With
// func = load, the row replaces row row_index of the stored right-hand matrix
// (identity after reset) and no result follows. With func = multiply, the row
// is taken as one row of a left-hand matrix; after it has passed the pipeline
// below, done is high for exactly one cycle with out_row, res_0..res_3 and
// overflow. The receiver cannot stall the block and must take each result in
// the cycle that done marks. Results come out in issue order, one per cycle at
// most. A multiply sees every load issued before it, also one issued in the
// cycle just before. Each result element is the exact sum of the four signed
// 64-bit products, shifted right by FRAC_BITS with rounding toward minus
// infinity and saturated to the signed 32-bit range; overflow flags that any
// of the four elements saturated. The pipeline runs from the input register
// through the product register (sixteen 32x32 multipliers) and the pair-sum
// register to the final add, shift and saturate into the result register.
module matrix4_row_multiply #(
    parameter int FRAC_BITS = m4rm_pkg::FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  logic           func,
    input  m4rm_pkg::row_t  row_index,
    input  m4rm_pkg::elem_t elem_0,
    input  m4rm_pkg::elem_t elem_1,
    input  m4rm_pkg::elem_t elem_2,
    input  m4rm_pkg::elem_t elem_3,
    output logic           done,
    output m4rm_pkg::row_t  out_row,
    output m4rm_pkg::elem_t res_0,
    output m4rm_pkg::elem_t res_1,
    output m4rm_pkg::elem_t res_2,
    output m4rm_pkg::elem_t res_3,
    output logic           overflow
);

    import m4rm_pkg::*;

    // Diagonal value of the identity in the chosen fixed-point format
    localparam elem_t ONE = elem_t'(1) << FRAC_BITS;

    elem_t in_elem [DIM];

    // Stored right-hand matrix, row-major
    elem_t mat_reg  [DIM][DIM];
    elem_t mat_next [DIM][DIM];

    // Stage 1: captured multiply row
    logic  s1_valid_reg, s1_valid_next;
    row_t  s1_row_reg,   s1_row_next;
    elem_t s1_elem_reg  [DIM];
    elem_t s1_elem_next [DIM];

    // Stage 2: all sixteen products, [k][c]
    logic  s2_valid_reg, s2_valid_next;
    row_t  s2_row_reg,   s2_row_next;
    prod_t s2_prod_reg  [DIM][DIM];
    prod_t s2_prod_next [DIM][DIM];

    // Stage 3: two pair sums per column
    logic  s3_valid_reg, s3_valid_next;
    row_t  s3_row_reg,   s3_row_next;
    pair_t s3_pair_reg  [DIM][2];
    pair_t s3_pair_next [DIM][2];

    // Result register
    logic  res_valid_reg, res_valid_next;
    row_t  res_row_reg,   res_row_next;
    elem_t res_reg  [DIM];
    elem_t res_next [DIM];
    logic  ovf_reg,  ovf_next;

    sum_t  col_sum     [DIM];
    sum_t  col_shifted [DIM];
    logic  col_sat     [DIM];

    logic  take;

    assign in_elem[0] = elem_0;
    assign in_elem[1] = elem_1;
    assign in_elem[2] = elem_2;
    assign in_elem[3] = elem_3;

    // Every cycle is open for a new transfer
    assign busy = 1'b0;
    assign take = start && !busy;

    // Matrix load: write the whole row at the transfer edge
    always_comb
    begin
        mat_next = mat_reg;
        if (take && func == FUNC_LOAD)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                mat_next[row_index][c] = in_elem[c];
            end
        end
    end

    // Capture multiply rows
    always_comb
    begin
        s1_valid_next = take && func == FUNC_MUL;
        s1_row_next   = row_index;
        s1_elem_next  = in_elem;
    end

    // Products: element k of the row times entry [k][c]
    always_comb
    begin
        s2_valid_next = s1_valid_reg;
        s2_row_next   = s1_row_reg;
        for (int k = 0; k < DIM; k++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                s2_prod_next[k][c] = prod_t'(s1_elem_reg[k]) * prod_t'(mat_reg[k][c]);
            end
        end
    end

    // Pair sums, full width
    always_comb
    begin
        s3_valid_next = s2_valid_reg;
        s3_row_next   = s2_row_reg;
        for (int c = 0; c < DIM; c++)
        begin
            s3_pair_next[c][0] = pair_t'(s2_prod_reg[0][c]) + pair_t'(s2_prod_reg[1][c]);
            s3_pair_next[c][1] = pair_t'(s2_prod_reg[2][c]) + pair_t'(s2_prod_reg[3][c]);
        end
    end

    // Final add, floor shift and saturate
    always_comb
    begin
        res_valid_next = s3_valid_reg;
        res_row_next   = s3_row_reg;
        ovf_next       = 1'b0;
        for (int c = 0; c < DIM; c++)
        begin
            col_sum[c]     = sum_t'(s3_pair_reg[c][0]) + sum_t'(s3_pair_reg[c][1]);
            col_shifted[c] = col_sum[c] >>> FRAC_BITS;
            // Fits when every bit above the 32-bit sign bit copies it
            col_sat[c]     = !((&col_shifted[c][SUM_W-1:ELEM_W-1]) ||
                               !(|col_shifted[c][SUM_W-1:ELEM_W-1]));
            if (col_sat[c])
            begin
                res_next[c] = col_shifted[c][SUM_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}}
                                                      : {1'b0, {(ELEM_W-1){1'b1}}};
            end
            else
            begin
                res_next[c] = col_shifted[c][ELEM_W-1:0];
            end
            ovf_next = ovf_next | col_sat[c];
        end
    end

    // Control state and the stored matrix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int r = 0; r < DIM; r++)
            begin
                for (int c = 0; c < DIM; c++)
                begin
                    mat_reg[r][c] <= (r == c) ? ONE : '0;
                end
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            res_valid_reg <= res_valid_next;
            mat_reg       <= mat_next;
        end
    end

    // Payload pipeline, no reset needed
    always_ff @(posedge clk)
    begin
        s1_row_reg   <= s1_row_next;
        s1_elem_reg  <= s1_elem_next;
        s2_row_reg   <= s2_row_next;
        s2_prod_reg  <= s2_prod_next;
        s3_row_reg   <= s3_row_next;
        s3_pair_reg  <= s3_pair_next;
        res_row_reg  <= res_row_next;
        res_reg      <= res_next;
        ovf_reg      <= ovf_next;
    end

    assign done     = res_valid_reg;
    assign out_row  = res_row_reg;
    assign res_0    = res_reg[0];
    assign res_1    = res_reg[1];
    assign res_2    = res_reg[2];
    assign res_3    = res_reg[3];
    assign overflow = ovf_reg;

endmodule
